FILE: rtl/rca_pkg.sv
package rca_pkg;

   localparam int DAYS_PER_MONTH = 30;

   localparam int SEC_MAX     = 59;
   localparam int MIN_MAX     = 59;
   localparam int HOUR_MAX    = 23;
   localparam int MONTH_MAX   = 12;
   localparam int YEAR_MAX    = 99;
   localparam int WEEKDAY_MAX = 6;

   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd1;
   localparam logic [2:0] OP_ON   = 3'd2;
   localparam logic [2:0] OP_OFF  = 3'd3;
   localparam logic [2:0] OP_ACK  = 3'd4;

   localparam logic CSR_ALARM_HOUR   = 1'b0;
   localparam logic CSR_ALARM_MINUTE = 1'b1;

   typedef struct packed {
      logic [2:0] operation;
      logic [5:0] load_second;
      logic [5:0] load_minute;
      logic [4:0] load_hour;
      logic [4:0] load_day;
      logic [3:0] load_month;
      logic [6:0] load_year;
      logic [2:0] load_weekday;
   } req_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [2:0] weekday;
      logic       alarm_enabled;
      logic       alarm_ringing;
      logic       buzzer;
   } rsp_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [2:0] weekday;
      logic       armed;
      logic       buzzer;
   } state_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
   } alarm_type;

   localparam state_type STATE_RESET = '{
      second:  6'd45,
      minute:  6'd59,
      hour:    5'd1,
      day:     5'd1,
      month:   4'd1,
      year:    7'd20,
      weekday: 3'd0,
      armed:   1'b0,
      buzzer:  1'b0
   };

endpackage

FILE: rtl/rca_req_if.sv
interface rca_req_if;
   logic             valid;
   logic             ready;
   rca_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rca_rsp_if.sv
interface rca_rsp_if;
   logic             valid;
   logic             ready;
   rca_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rca_step.sv
module rca_step (
   input  rca_pkg::state_type cur,
   input  rca_pkg::req_type   req,
   input  rca_pkg::alarm_type alarm,
   output rca_pkg::state_type nxt,
   output rca_pkg::rsp_type   rsp
);

   logic [6:0] sec_inc;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;
   logic [5:0] day_inc;
   logic [4:0] month_inc;
   logic [7:0] year_inc;
   logic       sec_wrap;
   logic       min_wrap;
   logic       hour_wrap;
   logic       day_wrap;
   logic       month_wrap;
   logic       year_wrap;
   logic       cur_match;
   logic       ring;

   assign sec_inc   = {1'b0, cur.second} + 7'd1;
   assign min_inc   = {1'b0, cur.minute} + 7'd1;
   assign hour_inc  = {1'b0, cur.hour} + 6'd1;
   assign day_inc   = {1'b0, cur.day} + 6'd1;
   assign month_inc = {1'b0, cur.month} + 5'd1;
   assign year_inc  = {1'b0, cur.year} + 8'd1;

   assign sec_wrap   = sec_inc > 7'(rca_pkg::SEC_MAX);
   assign min_wrap   = min_inc > 7'(rca_pkg::MIN_MAX);
   assign hour_wrap  = hour_inc > 6'(rca_pkg::HOUR_MAX);
   assign day_wrap   = day_inc > 6'(rca_pkg::DAYS_PER_MONTH);
   assign month_wrap = month_inc > 5'(rca_pkg::MONTH_MAX);
   assign year_wrap  = year_inc > 8'(rca_pkg::YEAR_MAX);

   assign cur_match = (cur.hour == alarm.hour) && (cur.minute == alarm.minute);

   always_comb begin
      nxt = cur;
      case (req.operation)
         rca_pkg::OP_TICK: begin
            nxt.second = sec_wrap ? 6'd0 : sec_inc[5:0];
            if (sec_wrap) begin
               nxt.minute = min_wrap ? 6'd0 : min_inc[5:0];
               if (min_wrap) begin
                  nxt.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
                  if (hour_wrap) begin
                     nxt.weekday = (cur.weekday >= 3'(rca_pkg::WEEKDAY_MAX)) ?
                                   3'd0 : cur.weekday + 3'd1;
                     nxt.day = day_wrap ? 5'd1 : day_inc[4:0];
                     if (day_wrap) begin
                        nxt.month = month_wrap ? 4'd1 : month_inc[3:0];
                        if (month_wrap) begin
                           nxt.year = year_wrap ? 7'd0 : year_inc[6:0];
                        end
                     end
                  end
               end
            end
         end
         rca_pkg::OP_LOAD: begin
            nxt.second  = req.load_second;
            nxt.minute  = req.load_minute;
            nxt.hour    = req.load_hour;
            nxt.day     = req.load_day;
            nxt.month   = req.load_month;
            nxt.year    = req.load_year;
            nxt.weekday = req.load_weekday;
         end
         rca_pkg::OP_ON: begin
            nxt.armed = 1'b1;
         end
         rca_pkg::OP_OFF: begin
            nxt.armed = 1'b0;
         end
         rca_pkg::OP_ACK: begin
            if (cur_match) begin
               nxt.armed = 1'b0;
            end
         end
         default: ;
      endcase

      ring = nxt.armed && (nxt.hour == alarm.hour) && (nxt.minute == alarm.minute);
      if ((req.operation == rca_pkg::OP_TICK) && ring) begin
         nxt.buzzer = ~cur.buzzer;
      end
   end

   always_comb begin
      rsp.second        = nxt.second;
      rsp.minute        = nxt.minute;
      rsp.hour          = nxt.hour;
      rsp.day           = nxt.day;
      rsp.month         = nxt.month;
      rsp.year          = nxt.year;
      rsp.weekday       = nxt.weekday;
      rsp.alarm_enabled = nxt.armed;
      rsp.alarm_ringing = ring;
      rsp.buzzer        = nxt.buzzer;
   end

endmodule

FILE: rtl/rtc_calendar_alarm.sv
// real-time clock with 30-day calendar and alarm
//
// req_chan carries one operation per transfer: tick, load of time and date,
// alarm on, alarm off or acknowledge. each accepted request produces exactly
// one response on rsp_chan holding the clock state after that operation,
// the alarm enable, the ringing flag and the buzzer bit.
// each response goes to the output register, or to the skid entry if that
// is full; a request is taken every cycle the skid is empty, as the update
// is a short carry chain over small counters from state to response register.
// a two-entry output stage (response register plus skid) keeps req ready
// while one response waits; req_chan.ready drops only when both are full,
// so a stalled receiver holds back the sender after two responses.
// csr_we writes alarm hour (index 0) or alarm minute (index 1); write only
// while no response is outstanding.
// synchronous reset sets the clock to 01:59:45, day 1, month 1, year 20,
// weekday 0, alarm off, buzzer low, alarm time 00:00, and empties the output.
module rtc_calendar_alarm (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [5:0]      csr_wdata,
   rca_req_if.sink         req_chan,
   rca_rsp_if.source       rsp_chan
);

   rca_pkg::state_type state_ff;
   rca_pkg::state_type state_in;
   rca_pkg::alarm_type alarm_ff;
   rca_pkg::rsp_type   step_rsp;
   rca_pkg::rsp_type   out_ff;
   rca_pkg::rsp_type   skid_ff;
   logic               out_valid_ff;
   logic               skid_valid_ff;
   logic               push;
   logic               pop;

   assign req_chan.ready = ~skid_valid_ff;
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = out_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   rca_step u_step (
      .cur   (state_ff),
      .req   (req_chan.data),
      .alarm (alarm_ff),
      .nxt   (state_in),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rca_pkg::STATE_RESET;
      end else if (push) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rca_pkg::CSR_ALARM_HOUR:   alarm_ff.hour   <= csr_wdata[4:0];
            rca_pkg::CSR_ALARM_MINUTE: alarm_ff.minute <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= step_rsp;
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_ff       <= step_rsp;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= step_rsp;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a response while the output register is empty");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !push |=> $stable(state_ff))
      else $error("clock state changed without a request transfer");

   a_buzzer_tick_only: assert property (@(posedge clock) disable iff (reset)
      (push && (req_chan.data.operation != rca_pkg::OP_TICK))
      |=> (state_ff.buzzer == $past(state_ff.buzzer)))
      else $error("buzzer changed on an operation other than a tick");

   a_ring_needs_enable: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_ff.alarm_ringing || out_ff.alarm_enabled))
      else $error("response rings while the alarm is disabled");

endmodule
